// ===== rtl/core/cwpt_pkg.sv =====
package cwpt_pkg;

	localparam int CORDIC_STEPS = 24;
	localparam int IW = $clog2(CORDIC_STEPS);

	localparam logic [1:0] OP_ODOM = 2'd0;
	localparam logic [1:0] OP_TAG  = 2'd1;
	localparam logic [1:0] OP_DET  = 2'd2;

	localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
	localparam logic signed [33:0] HALF_PI_Q28 = 34'sd421657428;

	typedef enum logic [1:0] {
		PH_QPROD = 2'd0,
		PH_QMUL  = 2'd1,
		PH_POS   = 2'd2,
		PH_WMUL  = 2'd3
	} phase_t;

	typedef struct packed {
		logic          accept;
		logic          wr_tag;
		logic          issue;
		phase_t        phase;
		logic [1:0]    row;
		logic [1:0]    col;
		logic [1:0]    k;
		logic          cinit;
		logic          citer;
		logic [IW-1:0] iter;
		logic          out_load;
	} cmd_t;

	typedef struct packed {
		logic fwd;
		logic out_busy;
	} stat_t;

	function automatic logic [3:0] idx9(input logic [1:0] r, input logic [1:0] c);
		return 4'(r) * 4'd3 + 4'(c);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -64'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	function automatic logic signed [31:0] mount_at(input logic fwd, input logic [3:0] i);
		logic signed [31:0] r;
		r = '0;
		if (fwd) begin
			case (i)
				4'd0: r = 32'sd4293845;
				4'd1: r = -32'sd33508716;
				4'd2: r = 32'sd1073210247;
				4'd3: r = -32'sd1073702050;
				4'd4: r = 32'sd8045921;
				4'd5: r = 32'sd4547029;
				4'd6: r = -32'sd8183839;
				4'd7: r = -32'sd1073188676;
				4'd8: r = -32'sd33475299;
				default: r = '0;
			endcase
		end else begin
			case (i)
				4'd0: r = 32'sd7395941;
				4'd1: r = -32'sd1073255748;
				4'd2: r = -32'sd31446835;
				4'd3: r = -32'sd1073671611;
				4'd4: r = -32'sd7679542;
				4'd5: r = 32'sd9581274;
				4'd6: r = -32'sd9801848;
				4'd7: r = 32'sd31378783;
				4'd8: r = -32'sd1073238464;
				default: r = '0;
			endcase
		end
		return r;
	endfunction

	function automatic logic signed [31:0] offs_at(input logic fwd, input logic [1:0] i);
		logic signed [31:0] r;
		r = '0;
		case ({fwd, i})
			3'b100: r = 32'sd410;
			3'b101: r = -32'sd5828;
			3'b110: r = 32'sd4214;
			3'b000: r = -32'sd265;
			3'b001: r = -32'sd4223;
			3'b010: r = 32'sd554;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [33:0] atan_q28(input logic [4:0] i);
		logic signed [33:0] r;
		r = '0;
		case (i)
			5'd0: r = 34'sd210828714;
			5'd1: r = 34'sd124459457;
			5'd2: r = 34'sd65760959;
			5'd3: r = 34'sd33381290;
			5'd4: r = 34'sd16755422;
			5'd5: r = 34'sd8385879;
			5'd6: r = 34'sd4193963;
			5'd7: r = 34'sd2097109;
			5'd8: r = 34'sd1048571;
			5'd9: r = 34'sd524287;
			default: begin
				if (i <= 5'd28)
					r = 34'sd1 <<< (5'd28 - i);
				else
					r = '0;
			end
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/cwpt_ctrl.sv =====
module cwpt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [1:0]          in_op,
	input  logic                in_found,
	output logic                in_ready,
	input  cwpt_pkg::stat_t     stat,
	output cwpt_pkg::cmd_t      cmd
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_QPROD = 8'b00000010,
		S_QMUL  = 8'b00000100,
		S_POS   = 8'b00001000,
		S_WMUL  = 8'b00010000,
		S_CINIT = 8'b00100000,
		S_CITER = 8'b01000000,
		S_OUT   = 8'b10000000
	} state_t;

	localparam logic [cwpt_pkg::IW-1:0] ITER_LAST = cwpt_pkg::IW'(cwpt_pkg::CORDIC_STEPS - 1);

	state_t state_q, state_d;
	logic [1:0] row_q, col_q, k_q, row_d, col_d, k_d;
	logic [1:0] kmax, colmax, rowmax;
	logic drain_q, drain_d;
	logic [cwpt_pkg::IW-1:0] iter_q, iter_d;
	logic phase_st;

	always_comb begin
		kmax = 2'd2;
		colmax = 2'd0;
		rowmax = 2'd2;
		case (state_q)
			S_QPROD: begin
				kmax = 2'd0;
				colmax = 2'd2;
			end
			S_QMUL: colmax = 2'd2;
			S_WMUL: rowmax = 2'd1;
			default: ;
		endcase
	end

	assign phase_st = (state_q == S_QPROD) || (state_q == S_QMUL) ||
		(state_q == S_POS) || (state_q == S_WMUL);

	always_comb begin
		state_d = state_q;
		row_d = row_q;
		col_d = col_q;
		k_d = k_q;
		drain_d = drain_q;
		iter_d = iter_q;
		in_ready = 1'b0;
		cmd = '0;
		cmd.row = row_q;
		cmd.col = col_q;
		cmd.k = k_q;
		cmd.iter = iter_q;
		case (state_q)
			S_QMUL: cmd.phase = cwpt_pkg::PH_QMUL;
			S_POS: cmd.phase = cwpt_pkg::PH_POS;
			S_WMUL: cmd.phase = cwpt_pkg::PH_WMUL;
			default: cmd.phase = cwpt_pkg::PH_QPROD;
		endcase

		if (phase_st) begin
			if (drain_q) begin
				drain_d = 1'b0;
				row_d = '0;
				col_d = '0;
				k_d = '0;
				case (state_q)
					S_QPROD: state_d = S_QMUL;
					S_POS: state_d = stat.fwd ? S_OUT : S_WMUL;
					S_WMUL: state_d = S_CINIT;
					default: state_d = S_IDLE;
				endcase
			end else begin
				cmd.issue = 1'b1;
				if (k_q == kmax) begin
					k_d = '0;
					if (col_q == colmax) begin
						col_d = '0;
						if (row_q == rowmax)
							drain_d = 1'b1;
						else
							row_d = row_q + 2'd1;
					end else begin
						col_d = col_q + 2'd1;
					end
				end else begin
					k_d = k_q + 2'd1;
				end
			end
		end

		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					case (in_op)
						cwpt_pkg::OP_ODOM: state_d = S_QPROD;
						cwpt_pkg::OP_TAG: cmd.wr_tag = 1'b1;
						cwpt_pkg::OP_DET: state_d = in_found ? S_POS : S_OUT;
						default: ;
					endcase
				end
			end
			S_CINIT: begin
				cmd.cinit = 1'b1;
				iter_d = '0;
				state_d = S_CITER;
			end
			S_CITER: begin
				cmd.citer = 1'b1;
				iter_d = iter_q + 1'b1;
				if (iter_q == ITER_LAST)
					state_d = S_OUT;
			end
			S_OUT: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			row_q <= '0;
			col_q <= '0;
			k_q <= '0;
			drain_q <= 1'b0;
			iter_q <= '0;
		end else begin
			state_q <= state_d;
			row_q <= row_d;
			col_q <= col_d;
			k_q <= k_d;
			drain_q <= drain_d;
			iter_q <= iter_d;
		end
	end

	a_odom_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && in_op == cwpt_pkg::OP_ODOM |=> state_q == S_QPROD)
		else $error("odometry item did not start product phase");

	a_cordic_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CITER && iter_q == ITER_LAST |=> state_q == S_OUT)
		else $error("cordic did not finish on its last iteration");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !stat.out_busy)
		else $error("result loaded over an unsent item");

endmodule

// ===== rtl/core/cwpt_dpath.sv =====
module cwpt_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  cwpt_pkg::cmd_t      cmd,
	output cwpt_pkg::stat_t     stat,
	input  logic                cfg_valid,
	input  logic [0:0]          cfg_data,
	input  logic [351:0]        s_tdata,
	input  logic [2:0]          s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [191:0]        m_tdata,
	output logic [0:0]          m_tuser
);

	logic fwd_q;
	logic signed [31:0] v_q [4];
	logic [63:0] stamp_q;
	logic found_q;
	logic signed [31:0] tag_q [9];
	logic signed [31:0] c2w_q [9];
	logic signed [31:0] pos_q [3];
	logic signed [33:0] rq_q [9];
	logic signed [31:0] wm0_q, wm3_q;
	logic signed [63:0] prod_s1, acc_q;
	logic issue_s1;
	cwpt_pkg::phase_t phase_s1;
	logic [1:0] row_s1, col_s1, k_s1;
	logic signed [35:0] cx_q, cy_q;
	logic signed [33:0] cz_q;
	logic czero_q;
	logic out_valid_q;

	logic signed [31:0] qm [9];
	logic signed [39:0] qw [9];
	logic signed [31:0] p [3];
	logic signed [31:0] opa, opb;
	logic signed [63:0] prod_w, acc_sum, rmul_w, rnd_w;
	logic signed [31:0] rnd32;
	logic signed [35:0] wx, wy, shx, shy;
	logic signed [33:0] at;
	logic signed [31:0] yaw;

	always_comb begin
		qw[0] = 40'(cwpt_pkg::ONE_Q30) - ((40'(rq_q[1]) + 40'(rq_q[2])) <<< 1);
		qw[1] = (40'(rq_q[3]) - 40'(rq_q[8])) <<< 1;
		qw[2] = (40'(rq_q[4]) + 40'(rq_q[7])) <<< 1;
		qw[3] = (40'(rq_q[3]) + 40'(rq_q[8])) <<< 1;
		qw[4] = 40'(cwpt_pkg::ONE_Q30) - ((40'(rq_q[0]) + 40'(rq_q[2])) <<< 1);
		qw[5] = (40'(rq_q[5]) - 40'(rq_q[6])) <<< 1;
		qw[6] = (40'(rq_q[4]) - 40'(rq_q[7])) <<< 1;
		qw[7] = (40'(rq_q[5]) + 40'(rq_q[6])) <<< 1;
		qw[8] = 40'(cwpt_pkg::ONE_Q30) - ((40'(rq_q[0]) + 40'(rq_q[1])) <<< 1);
		for (int i = 0; i < 9; i++)
			qm[i] = cwpt_pkg::sat32(64'(qw[i]));
		for (int i = 0; i < 3; i++)
			p[i] = cwpt_pkg::sat32(64'(v_q[i]) + 64'(cwpt_pkg::offs_at(fwd_q, 2'(i))));
	end

	// quaternion products: xx yy zz xy xz yz wx wy wz
	always_comb begin
		opa = '0;
		opb = '0;
		case (cmd.phase)
			cwpt_pkg::PH_QPROD: begin
				case (cwpt_pkg::idx9(cmd.row, cmd.col))
					4'd0: begin opa = v_q[0]; opb = v_q[0]; end
					4'd1: begin opa = v_q[1]; opb = v_q[1]; end
					4'd2: begin opa = v_q[2]; opb = v_q[2]; end
					4'd3: begin opa = v_q[0]; opb = v_q[1]; end
					4'd4: begin opa = v_q[0]; opb = v_q[2]; end
					4'd5: begin opa = v_q[1]; opb = v_q[2]; end
					4'd6: begin opa = v_q[3]; opb = v_q[0]; end
					4'd7: begin opa = v_q[3]; opb = v_q[1]; end
					4'd8: begin opa = v_q[3]; opb = v_q[2]; end
					default: ;
				endcase
			end
			cwpt_pkg::PH_QMUL: begin
				opa = qm[cwpt_pkg::idx9(cmd.row, cmd.k)];
				opb = cwpt_pkg::mount_at(fwd_q, cwpt_pkg::idx9(cmd.k, cmd.col));
			end
			cwpt_pkg::PH_POS: begin
				opa = c2w_q[cwpt_pkg::idx9(cmd.row, cmd.k)];
				opb = p[cmd.k];
			end
			cwpt_pkg::PH_WMUL: begin
				opa = c2w_q[cwpt_pkg::idx9(cmd.row, cmd.k)];
				opb = tag_q[cwpt_pkg::idx9(cmd.k, cmd.col)];
			end
			default: ;
		endcase
	end

	assign prod_w = opa * opb;
	assign rmul_w = (prod_s1 + 64'sd536870912) >>> 30;
	assign acc_sum = ((k_s1 == 2'd0) ? 64'sd0 : acc_q) + (prod_s1 >>> 2);
	assign rnd_w = (acc_sum + 64'sd134217728) >>> 28;
	assign rnd32 = cwpt_pkg::sat32(rnd_w);

	always_ff @(posedge clk) begin
		prod_s1 <= prod_w;
		phase_s1 <= cmd.phase;
		row_s1 <= cmd.row;
		col_s1 <= cmd.col;
		k_s1 <= cmd.k;
		if (issue_s1)
			acc_q <= acc_sum;
		if (issue_s1 && phase_s1 == cwpt_pkg::PH_QPROD)
			rq_q[cwpt_pkg::idx9(row_s1, col_s1)] <= rmul_w[33:0];
		if (issue_s1 && phase_s1 == cwpt_pkg::PH_WMUL && k_s1 == 2'd2) begin
			if (row_s1 == 2'd0)
				wm0_q <= rnd32;
			else
				wm3_q <= rnd32;
		end
		if (cmd.accept) begin
			for (int i = 0; i < 4; i++)
				v_q[i] <= s_tdata[32*i +: 32];
			stamp_q <= s_tdata[351:288];
			found_q <= s_tuser[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			issue_s1 <= 1'b0;
		else
			issue_s1 <= cmd.issue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
			for (int i = 0; i < 9; i++) begin
				tag_q[i] <= (i == 0 || i == 4 || i == 8) ? cwpt_pkg::ONE_Q30 : 32'sd0;
				c2w_q[i] <= cwpt_pkg::mount_at(1'b0, 4'(i));
			end
			for (int i = 0; i < 3; i++)
				pos_q[i] <= '0;
		end else begin
			if (cfg_valid)
				fwd_q <= cfg_data[0];
			if (cmd.wr_tag) begin
				for (int i = 0; i < 9; i++)
					tag_q[i] <= s_tdata[32*i +: 32];
			end
			if (issue_s1 && k_s1 == 2'd2) begin
				if (phase_s1 == cwpt_pkg::PH_QMUL)
					c2w_q[cwpt_pkg::idx9(row_s1, col_s1)] <= rnd32;
				if (phase_s1 == cwpt_pkg::PH_POS)
					pos_q[row_s1] <= rnd32;
			end
		end
	end

	assign wx = 36'(wm0_q);
	assign wy = 36'(wm3_q);
	assign shx = cx_q >>> cmd.iter;
	assign shy = cy_q >>> cmd.iter;
	assign at = cwpt_pkg::atan_q28(5'(cmd.iter));

	always_ff @(posedge clk) begin
		if (cmd.cinit) begin
			czero_q <= (wm0_q == 32'sd0) && (wm3_q == 32'sd0);
			if (wx < 0 && wy >= 0) begin
				cx_q <= wy;
				cy_q <= -wx;
				cz_q <= cwpt_pkg::HALF_PI_Q28;
			end else if (wx < 0) begin
				cx_q <= -wy;
				cy_q <= wx;
				cz_q <= -cwpt_pkg::HALF_PI_Q28;
			end else begin
				cx_q <= wx;
				cy_q <= wy;
				cz_q <= '0;
			end
		end else if (cmd.citer && !czero_q) begin
			if (cy_q >= 0) begin
				cx_q <= cx_q + shy;
				cy_q <= cy_q - shx;
				cz_q <= cz_q + at;
			end else begin
				cx_q <= cx_q - shy;
				cy_q <= cy_q + shx;
				cz_q <= cz_q - at;
			end
		end
	end

	assign yaw = (found_q && !fwd_q) ?
		cwpt_pkg::sat32(64'(cz_q) + 64'(cwpt_pkg::HALF_PI_Q28)) : 32'sd0;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata <= {yaw, stamp_q, pos_q[2], pos_q[1], pos_q[0]};
			m_tuser <= ~found_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	assign m_tvalid = out_valid_q;
	assign stat.fwd = fwd_q;
	assign stat.out_busy = out_valid_q && !m_tready;

	a_acc_first: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue && cmd.phase != cwpt_pkg::PH_QPROD && cmd.k != 2'd0 |-> $past(cmd.issue))
		else $error("dot product step without its predecessor");

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |=> out_valid_q && $stable(m_tdata))
		else $error("pending result changed");

	a_lost_no_yaw: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load && !found_q |=> m_tuser[0] && m_tdata[191:160] == 32'd0)
		else $error("lost item with nonzero yaw");

endmodule

// ===== rtl/core/camera_to_world_position_transform_core.sv =====
// channel | dir | handshake         | payload
// s       | in  | s_tvalid/s_tready | s_tdata: value_0..value_8, frame_time
//         |     |                   | s_tuser: op[1:0], tag_found[2]
// m       | out | m_tvalid/m_tready | m_tdata: world_x, world_y, world_z, stamp, heading
//         |     |                   | m_tuser: lost
// cfg     | in  | cfg_valid/cfg_ready (always ready) | cfg_data: forward_camera
//
// One item at a time through one shared 32x32 multiplier and one CORDIC stage.
// Odometry: 9 quaternion products and 27 matrix products, each group followed by a drain.
// Tag rotation: stored when the item is accepted. Lost detection: straight to output load.
// Found detection: position products; downward adds heading products and 24 CORDIC steps.
// Asynchronous reset loads the downward mount matrix, identity tag matrix, zero position.
// A result held by m_tready low stalls the next detection only at its output load.
module camera_to_world_position_transform_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [351:0]  s_tdata,  // value_0 .. value_8, frame_time
	input  logic [2:0]    s_tuser,  // op, tag_found
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [191:0]  m_tdata,  // world_x, world_y, world_z, stamp, heading
	output logic [0:0]    m_tuser,  // lost
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [0:0]    cfg_data
);

	cwpt_pkg::cmd_t  cmd;
	cwpt_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	cwpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_op    (s_tuser[1:0]),
		.in_found (s_tuser[2]),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cwpt_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

// ===== bench/camera_to_world_position_transform_core_test.sv =====
module camera_to_world_position_transform_core_test;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [1:0]         op;
		logic signed [31:0] val[9];
		logic               found;
		logic [63:0]        ftime;
	} pose_item_t;

	typedef struct {
		logic signed [31:0] wx;
		logic signed [31:0] wy;
		logic signed [31:0] wz;
		logic [63:0]        stamp;
		logic               lost;
		logic signed [31:0] yaw;
	} fix_t;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [351:0] s_tdata;
	logic [2:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [191:0] m_tdata;
	logic [0:0]   m_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [0:0]   cfg_data;

	camera_to_world_position_transform_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	pose_item_t pending_items[$];
	fix_t       expected_fixes[$];

	logic signed [31:0] c2w[9];
	logic signed [31:0] tag_rot[9];
	logic signed [31:0] last_pos[3];
	logic               fwd_mode;

	int  mismatches;
	int  fixes_seen;
	int  items_sent;
	int  idle_cycles;
	bit  calm;
	bit  hold_sink;
	bit  in_taken;
	int  src_gap;
	int  sink_gap;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic longint asr_l(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint round_q30(longint a, longint b);
		return asr_l(a * b + (64'sd1 <<< 29), 30);
	endfunction

	function automatic longint sum3_q(longint a0, longint b0, longint a1, longint b1,
			longint a2, longint b2);
		longint s;
		s = asr_l(a0 * b0, 2) + asr_l(a1 * b1, 2) + asr_l(a2 * b2, 2);
		return clamp32(asr_l(s + (64'sd1 <<< 27), 28));
	endfunction

	function automatic longint mount_entry(logic fwd, int i);
		longint down_m[9] = '{7395941, -1073255748, -31446835, -1073671611, -7679542,
			9581274, -9801848, 31378783, -1073238464};
		longint fwd_m[9] = '{4293845, -33508716, 1073210247, -1073702050, 8045921,
			4547029, -8183839, -1073188676, -33475299};
		return fwd ? fwd_m[i] : down_m[i];
	endfunction

	function automatic longint arctan_step(int i);
		longint tbl[10] = '{210828714, 124459457, 65760959, 33381290, 16755422,
			8385879, 4193963, 2097109, 1048571, 524287};
		if (i < 10)
			return tbl[i];
		if (i <= 28)
			return 64'sd1 <<< (28 - i);
		return 0;
	endfunction

	function automatic longint vector_angle(longint x, longint y);
		longint z, t, nx, ny;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = cwpt_pkg::HALF_PI_Q28;
			end else begin
				t = x; x = -y; y = t; z = -cwpt_pkg::HALF_PI_Q28;
			end
		end
		for (int i = 0; i < cwpt_pkg::CORDIC_STEPS; i++) begin
			if (y >= 0) begin
				nx = x + asr_l(y, i); ny = y - asr_l(x, i); z += arctan_step(i);
			end else begin
				nx = x - asr_l(y, i); ny = y + asr_l(x, i); z -= arctan_step(i);
			end
			x = nx; y = ny;
		end
		return z;
	endfunction

	task automatic reset_pose_state();
		for (int i = 0; i < 9; i++) begin
			c2w[i] = 32'(mount_entry(1'b0, i));
			tag_rot[i] = '0;
		end
		tag_rot[0] = cwpt_pkg::ONE_Q30;
		tag_rot[4] = cwpt_pkg::ONE_Q30;
		tag_rot[8] = cwpt_pkg::ONE_Q30;
		for (int i = 0; i < 3; i++)
			last_pos[i] = '0;
		fwd_mode = 1'b0;
	endtask

	task automatic predict_pose(input pose_item_t it);
		longint x, y, z, w, xx, yy, zz, xy, xz, yz, wx, wy, wz, yawv;
		longint q[9];
		longint p[3];
		logic signed [31:0] wm[9];
		fix_t f;
		case (it.op)
			cwpt_pkg::OP_ODOM: begin
				x = it.val[0]; y = it.val[1]; z = it.val[2]; w = it.val[3];
				xx = round_q30(x, x); yy = round_q30(y, y); zz = round_q30(z, z);
				xy = round_q30(x, y); xz = round_q30(x, z); yz = round_q30(y, z);
				wx = round_q30(w, x); wy = round_q30(w, y); wz = round_q30(w, z);
				q[0] = clamp32(cwpt_pkg::ONE_Q30 - 2 * (yy + zz));
				q[1] = clamp32(2 * (xy - wz));
				q[2] = clamp32(2 * (xz + wy));
				q[3] = clamp32(2 * (xy + wz));
				q[4] = clamp32(cwpt_pkg::ONE_Q30 - 2 * (xx + zz));
				q[5] = clamp32(2 * (yz - wx));
				q[6] = clamp32(2 * (xz - wy));
				q[7] = clamp32(2 * (yz + wx));
				q[8] = clamp32(cwpt_pkg::ONE_Q30 - 2 * (xx + yy));
				for (int r = 0; r < 3; r++)
					for (int c = 0; c < 3; c++)
						c2w[r*3+c] = 32'(sum3_q(q[r*3], mount_entry(fwd_mode, c),
							q[r*3+1], mount_entry(fwd_mode, 3+c),
							q[r*3+2], mount_entry(fwd_mode, 6+c)));
			end
			cwpt_pkg::OP_TAG: begin
				for (int i = 0; i < 9; i++)
					tag_rot[i] = it.val[i];
			end
			cwpt_pkg::OP_DET: begin
				yawv = 0;
				if (it.found) begin
					for (int i = 0; i < 3; i++)
						p[i] = clamp32(longint'(it.val[i]) +
							longint'(cwpt_pkg::offs_at(fwd_mode, 2'(i))));
					for (int i = 0; i < 3; i++)
						last_pos[i] = 32'(sum3_q(c2w[i*3], p[0], c2w[i*3+1], p[1],
							c2w[i*3+2], p[2]));
					if (!fwd_mode) begin
						for (int r = 0; r < 3; r++)
							for (int c = 0; c < 3; c++)
								wm[r*3+c] = 32'(sum3_q(c2w[r*3], tag_rot[c],
									c2w[r*3+1], tag_rot[3+c], c2w[r*3+2], tag_rot[6+c]));
						yawv = clamp32(vector_angle(wm[0], wm[3]) + cwpt_pkg::HALF_PI_Q28);
					end
				end
				f.wx = last_pos[0]; f.wy = last_pos[1]; f.wz = last_pos[2];
				f.stamp = it.ftime;
				f.lost = ~it.found;
				f.yaw = 32'(yawv);
				expected_fixes.push_back(f);
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch in %s: got %h, expected %h", what, got, want);
		mismatches++;
	endtask

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'($urandom_range(0, 65535)) - 32'sd32768;
			default: return $urandom;
		endcase
	endfunction

	function automatic pose_item_t make_item(logic [1:0] op);
		pose_item_t it;
		real a, b, c, d, n;
		it.op = op;
		for (int i = 0; i < 9; i++)
			it.val[i] = rand_word();
		it.found = $urandom_range(0, 4) != 0;
		it.ftime = {$urandom, $urandom};
		if (op == cwpt_pkg::OP_ODOM && $urandom_range(0, 3) != 0) begin
			a = $urandom_range(0, 2000) - 1000.0; b = $urandom_range(0, 2000) - 1000.0;
			c = $urandom_range(0, 2000) - 1000.0; d = $urandom_range(0, 2000) - 1000.0;
			n = $sqrt(a*a + b*b + c*c + d*d) + 1.0;
			it.val[0] = $rtoi(a / n * 1073741824.0); it.val[1] = $rtoi(b / n * 1073741824.0);
			it.val[2] = $rtoi(c / n * 1073741824.0); it.val[3] = $rtoi(d / n * 1073741824.0);
		end else if (op == cwpt_pkg::OP_TAG && $urandom_range(0, 3) != 0) begin
			for (int i = 0; i < 9; i++)
				it.val[i] = $signed($urandom_range(0, 1 << 31)) - (32'sd1 <<< 30);
		end else if (op == cwpt_pkg::OP_DET && $urandom_range(0, 3) != 0) begin
			for (int i = 0; i < 3; i++)
				it.val[i] = $signed($urandom_range(0, 1 << 24)) - (32'sd1 <<< 23);
		end
		return it;
	endfunction

	task automatic add_item(input pose_item_t it);
		pending_items.push_back(it);
		predict_pose(it);
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || expected_fixes.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_mode(input logic fwd);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= fwd;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		fwd_mode = fwd;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && !in_taken) begin
				s_tvalid <= 1'b1;
			end else if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				src_gap = $urandom_range(0, 4);
				s_tvalid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				s_tvalid <= 1'b1;
				for (int i = 0; i < 9; i++)
					s_tdata[i*32 +: 32] <= pending_items[0].val[i];
				s_tdata[288 +: 64] <= pending_items[0].ftime;
				s_tuser <= {pending_items[0].found, pending_items[0].op};
			end else
				s_tvalid <= 1'b0;

			if (hold_sink)
				m_tready <= 1'b0;
			else if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				sink_gap = $urandom_range(0, 4);
				m_tready <= 1'b0;
			end else
				m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		fix_t f;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				void'(pending_items.pop_front());
				items_sent++;
				in_taken = 1'b1;
			end else
				in_taken = 1'b0;
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (m_tvalid && m_tready) begin
				fixes_seen++;
				if (expected_fixes.size() == 0) begin
					report_mismatch("unexpected item", m_tdata[63:0], '0);
				end else begin
					f = expected_fixes.pop_front();
					if (m_tdata[31:0] !== f.wx)
						report_mismatch("world_x", m_tdata[31:0], f.wx);
					if (m_tdata[63:32] !== f.wy)
						report_mismatch("world_y", m_tdata[63:32], f.wy);
					if (m_tdata[95:64] !== f.wz)
						report_mismatch("world_z", m_tdata[95:64], f.wz);
					if (m_tdata[159:96] !== f.stamp)
						report_mismatch("stamp", m_tdata[159:96], f.stamp);
					if (m_tdata[191:160] !== f.yaw)
						report_mismatch("heading", m_tdata[191:160], f.yaw);
					if (m_tuser[0] !== f.lost)
						report_mismatch("lost", m_tuser, f.lost);
				end
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired");
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		pose_item_t it;
		arst_n = 1'b0;
		s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
		m_tready = 1'b0; cfg_valid = 1'b0; cfg_data = '0;
		mismatches = 0; fixes_seen = 0; items_sent = 0; idle_cycles = 0;
		calm = 1'b0; hold_sink = 1'b0; in_taken = 1'b0; src_gap = 0; sink_gap = 0;
		reset_pose_state();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// lost before any found, then zero vector for yaw
		it = make_item(cwpt_pkg::OP_DET); it.found = 1'b0; it.ftime = '1; add_item(it);
		it = make_item(cwpt_pkg::OP_TAG); it.val = '{default: 0}; add_item(it);
		it = make_item(cwpt_pkg::OP_DET); it.found = 1'b1; it.val[0] = 0; it.ftime = '0;
		add_item(it);
		it = make_item(cwpt_pkg::OP_TAG);
		it.val = '{cwpt_pkg::ONE_Q30, 0, 0, 0, cwpt_pkg::ONE_Q30, 0, 0, 0,
			cwpt_pkg::ONE_Q30};
		add_item(it);
		it = make_item(cwpt_pkg::OP_DET); it.found = 1'b1;
		it.val[0] = 32'sh7fffffff; it.val[1] = 32'sh80000000; it.val[2] = 32'sh7fffffff;
		add_item(it);
		it = make_item(cwpt_pkg::OP_DET); it.found = 1'b1;
		it.val[0] = 32'sh80000000; it.val[1] = 32'sh7fffffff; it.val[2] = 32'sh80000000;
		add_item(it);
		it = make_item(cwpt_pkg::OP_ODOM); it.val[0] = 0; it.val[1] = 0; it.val[2] = 0;
		it.val[3] = cwpt_pkg::ONE_Q30; add_item(it);
		it = make_item(cwpt_pkg::OP_DET); it.found = 1'b1; add_item(it);
		it = make_item(cwpt_pkg::OP_ODOM);
		for (int i = 0; i < 4; i++) it.val[i] = 32'sh7fffffff;
		add_item(it);
		it = make_item(cwpt_pkg::OP_DET); it.found = 1'b1; add_item(it);
		it = make_item(cwpt_pkg::OP_ODOM);
		for (int i = 0; i < 4; i++) it.val[i] = 32'sh80000000;
		add_item(it);
		it = make_item(cwpt_pkg::OP_DET); it.found = 1'b1; add_item(it);
		it = make_item(OP_UNUSED); add_item(it);
		it = make_item(cwpt_pkg::OP_DET); it.found = 1'b0; add_item(it);
		wait_drained();

		set_mode(1'b1);
		it = make_item(cwpt_pkg::OP_DET); it.found = 1'b1; add_item(it);
		it = make_item(cwpt_pkg::OP_ODOM); add_item(it);
		it = make_item(cwpt_pkg::OP_DET); it.found = 1'b1; add_item(it);
		it = make_item(cwpt_pkg::OP_DET); it.found = 1'b0; add_item(it);
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			set_mode(phase[0]);
			if (phase == 1) begin
				fork
					begin
						hold_sink = 1'b1;
						repeat (400) @(posedge clk);
						hold_sink = 1'b0;
					end
				join_none
			end
			if (phase == 3)
				calm = 1'b1;
			for (int n = 0; n < 185; n++) begin
				case ($urandom_range(0, 19))
					0, 1, 2, 3: add_item(make_item(cwpt_pkg::OP_ODOM));
					4, 5, 6: add_item(make_item(cwpt_pkg::OP_TAG));
					7: add_item(make_item(OP_UNUSED));
					default: add_item(make_item(cwpt_pkg::OP_DET));
				endcase
			end
			wait_drained();
		end

		$display("sent %0d items over both camera mounts, checked %0d results", items_sent,
			fixes_seen);
		$display("covered odometry, tag rotation, found and lost detections, unknown ops");
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/cwpt_pkg.sv
rtl/core/cwpt_ctrl.sv
rtl/core/cwpt_dpath.sv
rtl/core/camera_to_world_position_transform_core.sv
bench/camera_to_world_position_transform_core_test.sv
